@@ design/ddq_pkg.sv @@
// ----------------------------------------------------------------------------
// ddq_pkg: shared types and constants of the double-ended queue
// Holds the action and status codes, the control state encoding, the per-cell
// command and the control bundle passed from the sequencer to the cell row.
// ----------------------------------------------------------------------------
package ddq_pkg;

  // Default number of cells in the row
  localparam int unsigned DepthDef = 256;
  // Width of one stored value
  localparam int unsigned DataW    = 32;
  // Width of the reported item count
  localparam int unsigned ItemCntW = 9;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  typedef enum logic [1:0] {
    CMD_HOLD       = 2'd0,
    CMD_SHIFT_UP   = 2'd1,
    CMD_SHIFT_DOWN = 2'd2,
    CMD_LOAD       = 2'd3
  } cell_cmd_e;

  // Control bundle from the sequencer to the cell row
  typedef struct packed {
    logic    shift_up;    // push at the front: every value moves one cell up
    logic    shift_down;  // pop at the front: every value moves one cell down
    logic    load_back;   // push at the back: the cell past the last one loads
    logic    take_front;  // a pop at the front succeeds
    logic    take_back;   // a pop at the back succeeds
    logic    accept;      // a transaction is taken this cycle
    logic    read_ends;   // sample the front and back cells
    status_e status;      // status of the transaction being taken
  } chain_ctrl_t;

endpackage

@@ design/double_ended_queue_top.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded double-ended queue of signed values
// A taken transaction updates the cell row and the fill count and is then
// answered after the read of the new end cells; no new transaction is taken
// during that read. The result strobe is high for one cycle and cannot be
// held off. Reset clears the fill count and the sequencer; cell contents are
// not cleared and are only read once written.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
  parameter int unsigned Depth = ddq_pkg::DepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         action_i,
  input  logic signed [ddq_pkg::DataW-1:0]   value_i,
  output logic                               done_o,
  output logic signed [ddq_pkg::DataW-1:0]   removed_value_o,
  output logic [1:0]                         status_o,
  output logic [ddq_pkg::ItemCntW-1:0]       item_count_o,
  output logic signed [ddq_pkg::DataW-1:0]   front_value_o,
  output logic signed [ddq_pkg::DataW-1:0]   back_value_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned IdxW = $clog2(Depth);

  ddq_pkg::chain_ctrl_t             ctl;
  logic [CntW-1:0]                  count;
  logic [IdxW-1:0]                  back_idx;
  logic signed [ddq_pkg::DataW-1:0] cells [Depth];
  logic signed [ddq_pkg::DataW-1:0] removed;

  logic                             done_q;
  logic signed [ddq_pkg::DataW-1:0] removed_q;
  ddq_pkg::status_e                 status_q;
  logic [ddq_pkg::ItemCntW-1:0]     item_count_q;
  logic signed [ddq_pkg::DataW-1:0] front_q;
  logic signed [ddq_pkg::DataW-1:0] back_q;

  ddq_ctrl #(
    .Depth (Depth)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (action_i),
    .busy_o   (busy),
    .ctl_o    (ctl),
    .count_o  (count)
  );

  // Row of cells; the front sits in cell zero
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    ddq_pkg::cell_cmd_e               cmd;
    logic signed [ddq_pkg::DataW-1:0] lower;
    logic signed [ddq_pkg::DataW-1:0] upper;

    always_comb begin
      if (ctl.shift_up) begin
        cmd = ddq_pkg::CMD_SHIFT_UP;
      end else if (ctl.shift_down) begin
        cmd = ddq_pkg::CMD_SHIFT_DOWN;
      end else if (ctl.load_back && (count == CntW'(i))) begin
        cmd = ddq_pkg::CMD_LOAD;
      end else begin
        cmd = ddq_pkg::CMD_HOLD;
      end
    end

    if (i == 0) begin : g_first
      assign lower = value_i;
    end else begin : g_lower
      assign lower = cells[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign upper = cells[i];
    end else begin : g_upper
      assign upper = cells[i+1];
    end

    ddq_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .lower_i (lower),
      .upper_i (upper),
      .value_i (value_i),
      .data_o  (cells[i])
    );
  end

  // Back cell sits one below the fill count
  assign back_idx = IdxW'(count - 1'b1);

  // Pick the value leaving the queue; the back was sampled after the last item
  always_comb begin
    if (ctl.take_front) begin
      removed = cells[0];
    end else if (ctl.take_back) begin
      removed = back_q;
    end else begin
      removed = '0;
    end
  end

  // Strobe the result once the ends have been read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl.read_ends;
    end
  end

  // Latch removed value and status on the transaction, ends after the update
  always_ff @(posedge clk_i) begin
    if (ctl.accept) begin
      removed_q <= removed;
      status_q  <= ctl.status;
    end
    if (ctl.read_ends) begin
      item_count_q <= ddq_pkg::ItemCntW'(count);
      if (count == '0) begin
        front_q <= '0;
        back_q  <= '0;
      end else begin
        front_q <= cells[0];
        back_q  <= cells[back_idx];
      end
    end
  end

  assign done_o          = done_q;
  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign item_count_o    = item_count_q;
  assign front_value_o   = front_q;
  assign back_value_o    = back_q;

`ifndef SYNTHESIS
  // A taken transaction keeps the block busy for the read cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transaction taken without entering the read cycle");

  // The read cycle is always followed by the result strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (done_o && !busy))
    else $error("read cycle not followed by a result");

  // An empty queue reports zero at both ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (item_count_o == '0) && (Depth < 512)) |->
      ((front_value_o == '0) && (back_value_o == '0)))
    else $error("empty queue reports non-zero end values");

  // Overflow is only reported on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ddq_pkg::ST_OVERFLOW)) |->
      (item_count_o == ddq_pkg::ItemCntW'(Depth)))
    else $error("overflow reported on a queue that is not full");

  // Underflow is only reported on an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ddq_pkg::ST_UNDERFLOW) && (Depth < 512)) |->
      (item_count_o == '0))
    else $error("underflow reported on a queue that is not empty");
`endif

endmodule

@@ design/ddq_cell.sv @@
// ----------------------------------------------------------------------------
// ddq_cell: one storage cell of the queue row
// Holds one value and, per command, keeps it, takes the value of the lower
// or upper neighbour, or loads the pushed value.
// ----------------------------------------------------------------------------
module ddq_cell (
  input  logic                                clk_i,
  input  ddq_pkg::cell_cmd_e                  cmd_i,
  input  logic signed [ddq_pkg::DataW-1:0]    lower_i,
  input  logic signed [ddq_pkg::DataW-1:0]    upper_i,
  input  logic signed [ddq_pkg::DataW-1:0]    value_i,
  output logic signed [ddq_pkg::DataW-1:0]    data_o
);

  logic signed [ddq_pkg::DataW-1:0] data_q;
  logic signed [ddq_pkg::DataW-1:0] data_d;

  // Select the next content of the cell
  always_comb begin
    case (cmd_i)
      ddq_pkg::CMD_SHIFT_UP:   data_d = lower_i;
      ddq_pkg::CMD_SHIFT_DOWN: data_d = upper_i;
      ddq_pkg::CMD_LOAD:       data_d = value_i;
      default:                 data_d = data_q;
    endcase
  end

  // Hold the value
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ design/ddq_ctrl.sv @@
// ----------------------------------------------------------------------------
// ddq_ctrl: sequencer of the double-ended queue
// Takes a transaction, checks it against the fill count, drives the cell row
// and steps through the read of the new end values.
// ----------------------------------------------------------------------------
module ddq_ctrl #(
  parameter int unsigned Depth = ddq_pkg::DepthDef,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [1:0]            action_i,
  output logic                  busy_o,
  output ddq_pkg::chain_ctrl_t  ctl_o,
  output logic [CntW-1:0]       count_o
);

  ddq_pkg::state_e  state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             accept;
  logic             full;
  logic             empty;
  ddq_pkg::action_e action;

  assign action = ddq_pkg::action_e'(action_i);
  assign full   = (count_q == CntW'(Depth));
  assign empty  = (count_q == '0);
  assign accept = start_i && (state_q == ddq_pkg::S_IDLE);

  // Hold state and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ddq_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Decide the action on the row, the status and the next count
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ctl_o   = '0;
    ctl_o.status    = ddq_pkg::ST_OK;
    ctl_o.accept    = accept;
    ctl_o.read_ends = (state_q == ddq_pkg::S_READ);
    case (state_q)
      ddq_pkg::S_IDLE: begin
        if (accept) begin
          state_d = ddq_pkg::S_READ;
          case (action)
            ddq_pkg::ACT_PUSH_FRONT,
            ddq_pkg::ACT_PUSH_BACK: begin
              if (full) begin
                ctl_o.status = ddq_pkg::ST_OVERFLOW;
              end else begin
                ctl_o.shift_up  = (action == ddq_pkg::ACT_PUSH_FRONT);
                ctl_o.load_back = (action == ddq_pkg::ACT_PUSH_BACK);
                count_d         = count_q + 1'b1;
              end
            end
            ddq_pkg::ACT_POP_FRONT,
            ddq_pkg::ACT_POP_BACK: begin
              if (empty) begin
                ctl_o.status = ddq_pkg::ST_UNDERFLOW;
              end else begin
                ctl_o.shift_down = (action == ddq_pkg::ACT_POP_FRONT);
                ctl_o.take_front = (action == ddq_pkg::ACT_POP_FRONT);
                ctl_o.take_back  = (action == ddq_pkg::ACT_POP_BACK);
                count_d          = count_q - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ddq_pkg::S_READ: begin
        state_d = ddq_pkg::S_IDLE;
      end
      default: begin
        state_d = ddq_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o  = (state_q == ddq_pkg::S_READ);
  assign count_o = count_q;

endmodule

@@ sim/double_ended_queue_checker.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_checker: scoreboard for the double-ended queue
// Watches the command and result channels, keeps a shadow ring of the queue
// contents, predicts the answer to every accepted transaction and compares
// each strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module double_ended_queue_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic [1:0]                        action_i,
  input  logic [ddq_pkg::DataW-1:0]         value_i,
  input  logic                              done_i,
  input  logic [ddq_pkg::DataW-1:0]         removed_value_i,
  input  logic [1:0]                        status_i,
  input  logic [ddq_pkg::ItemCntW-1:0]      item_count_i,
  input  logic [ddq_pkg::DataW-1:0]         front_value_i,
  input  logic [ddq_pkg::DataW-1:0]         back_value_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  localparam int Depth = ddq_pkg::DepthDef;

  typedef struct {
    logic [ddq_pkg::DataW-1:0]    removed;
    ddq_pkg::status_e             status;
    logic [ddq_pkg::ItemCntW-1:0] count;
    logic [ddq_pkg::DataW-1:0]    front;
    logic [ddq_pkg::DataW-1:0]    back;
  } deque_answer_t;

  // Shadow copy of the queue
  logic [ddq_pkg::DataW-1:0] shadow_ring [Depth];
  int                        head_idx;
  int                        fill;

  deque_answer_t             answer_q [$];

  // Apply one action to the shadow queue and return the answer it gives
  function automatic deque_answer_t apply_action(ddq_pkg::action_e act,
                                                 logic [ddq_pkg::DataW-1:0] val);
    deque_answer_t ans;
    ans.removed = '0;
    ans.status  = ddq_pkg::ST_OK;
    case (act)
      ddq_pkg::ACT_PUSH_FRONT, ddq_pkg::ACT_PUSH_BACK: begin
        if (fill >= Depth) begin
          ans.status = ddq_pkg::ST_OVERFLOW;
        end else if (act == ddq_pkg::ACT_PUSH_FRONT) begin
          head_idx = (head_idx + Depth - 1) % Depth;
          shadow_ring[head_idx] = val;
          fill++;
        end else begin
          shadow_ring[(head_idx + fill) % Depth] = val;
          fill++;
        end
      end
      default: begin
        if (fill == 0) begin
          ans.status = ddq_pkg::ST_UNDERFLOW;
        end else if (act == ddq_pkg::ACT_POP_FRONT) begin
          ans.removed = shadow_ring[head_idx];
          head_idx = (head_idx + 1) % Depth;
          fill--;
        end else begin
          ans.removed = shadow_ring[(head_idx + fill - 1) % Depth];
          fill--;
        end
      end
    endcase
    ans.count = fill[ddq_pkg::ItemCntW-1:0];
    if (fill == 0) begin
      ans.front = '0;
      ans.back  = '0;
    end else begin
      ans.front = shadow_ring[head_idx];
      ans.back  = shadow_ring[(head_idx + fill - 1) % Depth];
    end
    return ans;
  endfunction

  // Report one field that differs from its prediction
  task automatic compare_field(string name, logic [ddq_pkg::DataW-1:0] exp_v,
                               logic [ddq_pkg::DataW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // Check results first, then predict the transaction taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    deque_answer_t exp_ans;
    if (!rst_ni) begin
      head_idx     = 0;
      fill         = 0;
      answer_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (done_i) begin
        if (answer_q.size() == 0) begin
          $error("result strobe with no transaction outstanding");
          fail_count_o++;
        end else begin
          exp_ans = answer_q.pop_front();
          compare_field("removed_value", exp_ans.removed, removed_value_i);
          compare_field("status", exp_ans.status, status_i);
          compare_field("item_count", exp_ans.count, item_count_i);
          compare_field("front_value", exp_ans.front, front_value_i);
          compare_field("back_value", exp_ans.back, back_value_i);
        end
      end
      if (start_i && !busy_i) begin
        answer_q.push_back(apply_action(ddq_pkg::action_e'(action_i), value_i));
      end
      pending_o = answer_q.size();
    end
  end

endmodule

@@ sim/tb_double_ended_queue_top.sv @@
// ----------------------------------------------------------------------------
// tb_double_ended_queue_top: testbench for the double-ended queue
// Drives a directed run over the empty, wrap and extreme-value cases, then
// random runs biased towards filling and draining so that both overflow and
// underflow are reached, with random idle bursts. The checker does the
// prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;

  localparam int CycleLimit = 250000;
  localparam int SegLen     = 300;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [1:0]                   act_drv;
  logic [ddq_pkg::DataW-1:0]    value_drv;
  logic                         done;
  logic [ddq_pkg::DataW-1:0]    removed_value;
  logic [1:0]                   status;
  logic [ddq_pkg::ItemCntW-1:0] item_count;
  logic [ddq_pkg::DataW-1:0]    front_value;
  logic [ddq_pkg::DataW-1:0]    back_value;
  int                           fail_count;
  int                           pending;
  int                           cycles;
  bit                           idling_on;

  double_ended_queue_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .action_i        (act_drv),
    .value_i         (value_drv),
    .done_o          (done),
    .removed_value_o (removed_value),
    .status_o        (status),
    .item_count_o    (item_count),
    .front_value_o   (front_value),
    .back_value_o    (back_value)
  );

  double_ended_queue_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .action_i        (act_drv),
    .value_i         (value_drv),
    .done_i          (done),
    .removed_value_i (removed_value),
    .status_i        (status),
    .item_count_i    (item_count),
    .front_value_i   (front_value),
    .back_value_i    (back_value),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Issue one transaction, with an optional idle burst before it
  task automatic issue(input ddq_pkg::action_e act, input logic [ddq_pkg::DataW-1:0] val);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    act_drv   <= act;
    value_drv <= val;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  initial begin
    int                         push_bias [6];
    int                         seg;
    logic [ddq_pkg::DataW-1:0]  val;
    ddq_pkg::action_e           act;
    push_bias = '{95, 5, 50, 97, 3, 50};
    idling_on = 1'b0;
    rst_n     = 1'b0;
    start     <= 1'b0;
    act_drv   <= ddq_pkg::ACT_PUSH_FRONT;
    value_drv <= '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: pops on empty, extreme values, front wrap, emptying pops
    issue(ddq_pkg::ACT_POP_FRONT, 32'h1234_5678);
    issue(ddq_pkg::ACT_POP_BACK, 32'hFFFF_FFFF);
    issue(ddq_pkg::ACT_PUSH_FRONT, 32'h7FFF_FFFF);
    issue(ddq_pkg::ACT_PUSH_BACK, 32'h8000_0000);
    issue(ddq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF);
    issue(ddq_pkg::ACT_PUSH_BACK, 32'h0000_0000);
    issue(ddq_pkg::ACT_POP_FRONT, '0);
    issue(ddq_pkg::ACT_POP_BACK, '0);
    issue(ddq_pkg::ACT_POP_BACK, '0);
    issue(ddq_pkg::ACT_POP_FRONT, '0);
    issue(ddq_pkg::ACT_POP_FRONT, '0);
    issue(ddq_pkg::ACT_PUSH_BACK, 32'h0000_0001);
    issue(ddq_pkg::ACT_POP_FRONT, '0);
    issue(ddq_pkg::ACT_POP_BACK, '0);
    issue(ddq_pkg::ACT_PUSH_FRONT, 32'h5555_5555);
    issue(ddq_pkg::ACT_PUSH_BACK, 32'hAAAA_AAAA);
    issue(ddq_pkg::ACT_PUSH_FRONT, 32'h0F0F_0F0F);
    issue(ddq_pkg::ACT_POP_BACK, '0);
    issue(ddq_pkg::ACT_POP_BACK, '0);
    issue(ddq_pkg::ACT_POP_BACK, '0);
    issue(ddq_pkg::ACT_POP_FRONT, '0);

    // Random: alternate filling, draining and balanced runs; no idling at the end
    for (seg = 0; seg < 6; seg++) begin
      idling_on = (seg != 5);
      repeat (SegLen) begin
        if ($urandom_range(0, 99) < push_bias[seg]) begin
          act = $urandom_range(0, 1) ? ddq_pkg::ACT_PUSH_BACK : ddq_pkg::ACT_PUSH_FRONT;
        end else begin
          act = $urandom_range(0, 1) ? ddq_pkg::ACT_POP_BACK : ddq_pkg::ACT_POP_FRONT;
        end
        case ($urandom_range(0, 7))
          0:       val = 32'h7FFF_FFFF;
          1:       val = 32'h8000_0000;
          2:       val = 32'h0000_0000;
          3:       val = 32'hFFFF_FFFF;
          default: val = $urandom;
        endcase
        issue(act, val);
      end
    end
    start <= 1'b0;

    // Drain the outstanding results, then allow a few spare cycles
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
